FILE: hw/rtl/lzwsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwsd_pkg
// shared types, constants and helpers of the lzw stream decoder
// ----------------------------------------------------------------------------
package lzwsd_pkg;

  localparam int LZWSD_DICT_SIZE     = 4096;
  localparam int LZWSD_MAX_CODE_BITS = 12;

  localparam int CODE_CLEAR = 256;
  localparam int CODE_END   = 257;
  localparam int CODE_FIRST = 258;
  localparam int START_BITS = 9;

  localparam int CNT_W  = 24;
  localparam int BUF_W  = 24;
  localparam int FILL_W = 5;
  localparam int FILL_FULL_AT = 16;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_RETRY    = 3'd1,
    ST_BYTE     = 3'd2,
    ST_NEED     = 3'd3,
    ST_DONE     = 3'd4,
    ST_ERROR    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    END_RUN  = 2'd0,
    END_DONE = 2'd1,
    END_ERR  = 2'd2
  } ended_t;

  typedef enum logic [2:0] {
    CK_CLEAR,
    CK_END,
    CK_BAD,
    CK_LIT,
    CK_DATA
  } code_kind_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_PUSH,
    DP_CONSUME,
    DP_FIRSTLIT,
    DP_START,
    DP_FIRST,
    DP_WALK,
    DP_TERM,
    DP_POP
  } dp_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_FIRST,
    S_WALK,
    S_WALKD,
    S_RD,
    S_POP
  } state_t;

  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    status_t          status;
    logic [CNT_W-1:0] out_count;
  } out_item_t;

  typedef struct packed {
    dp_op_t  op;
    logic    out_load;
    status_t out_status;
    logic    set_ended;
    ended_t  ended_val;
  } dp_cmd_t;

  typedef struct packed {
    ended_t     ended;
    logic       closed;
    logic       fill_full;
    logic       limit_hit;
    logic       stack_empty;
    logic       bits_short;
    code_kind_t code_kind;
    logic       cur_lit;
  } dp_stat_t;

  function automatic logic [5:0] bit_len(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        n = 6'(i + 1);
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/lzwsd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwsd_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lzwsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lzwsd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwsd_ctrl
// sequencing state machine: handshakes, code fetch, chain walk and pop
// ----------------------------------------------------------------------------
module lzwsd_ctrl
  import lzwsd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_func,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state, state_next;
  logic   accept;

  assign in_stall = !((state == S_IDLE) && (!out_valid || !out_stall));
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && stat.ended == END_RUN && in_func && !stat.limit_hit) begin
          state_next = stat.stack_empty ? S_FETCH : S_POP;
        end
      end
      S_FETCH: begin
        if (stat.bits_short) begin
          state_next = S_IDLE;
        end else begin
          case (stat.code_kind)
            CK_CLEAR: state_next = S_FETCH;
            CK_LIT:   state_next = S_RD;
            CK_DATA:  state_next = S_FIRST;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_FIRST: state_next = S_WALK;
      S_WALK:  state_next = stat.cur_lit ? S_RD : S_WALKD;
      S_WALKD: state_next = S_WALK;
      S_RD:    state_next = S_POP;
      S_POP:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{op: DP_NOP, out_load: 1'b0, out_status: ST_ACCEPTED,
            set_ended: 1'b0, ended_val: END_RUN};
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (stat.ended != END_RUN) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = (stat.ended == END_DONE) ? ST_DONE : ST_ERROR;
          end else if (!in_func) begin
            cmd.out_load = 1'b1;
            if (stat.closed) begin
              cmd.out_status = ST_ACCEPTED;
            end else if (stat.fill_full) begin
              cmd.out_status = ST_RETRY;
            end else begin
              cmd.op         = DP_PUSH;
              cmd.out_status = ST_ACCEPTED;
            end
          end else if (stat.limit_hit) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = ST_DONE;
            cmd.set_ended  = 1'b1;
            cmd.ended_val  = END_DONE;
          end
        end
      end
      S_FETCH: begin
        if (stat.bits_short) begin
          cmd.out_load = 1'b1;
          if (stat.closed) begin
            cmd.out_status = ST_ERROR;
            cmd.set_ended  = 1'b1;
            cmd.ended_val  = END_ERR;
          end else begin
            cmd.out_status = ST_NEED;
          end
        end else begin
          case (stat.code_kind)
            CK_CLEAR: cmd.op = DP_CONSUME;
            CK_END: begin
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_DONE;
              cmd.set_ended  = 1'b1;
              cmd.ended_val  = END_DONE;
            end
            CK_LIT:  cmd.op = DP_FIRSTLIT;
            CK_DATA: cmd.op = DP_START;
            default: begin
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_ERROR;
              cmd.set_ended  = 1'b1;
              cmd.ended_val  = END_ERR;
            end
          endcase
        end
      end
      S_FIRST: cmd.op = DP_FIRST;
      S_WALK: begin
        if (stat.cur_lit) begin
          cmd.op = DP_TERM;
        end
      end
      S_WALKD: cmd.op = DP_WALK;
      S_POP: begin
        cmd.op         = DP_POP;
        cmd.out_load   = 1'b1;
        cmd.out_status = ST_BYTE;
      end
      default: cmd.op = DP_NOP;
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lzwsd_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwsd_dpath
// bit buffer, dictionary tables, expansion stack and result register
// ----------------------------------------------------------------------------
module lzwsd_dpath
  import lzwsd_pkg::*;
#(
  parameter int DICT_SIZE     = LZWSD_DICT_SIZE,
  parameter int MAX_CODE_BITS = LZWSD_MAX_CODE_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire in_item_t         in_data,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire dp_cmd_t          cmd,
  output dp_stat_t              stat,
  output out_item_t             out_data
);

  localparam int AW = $clog2(DICT_SIZE);
  localparam int NW = AW + 1;
  localparam int CB = MAX_CODE_BITS;
  localparam int CW = $clog2(MAX_CODE_BITS + 1);

  logic [BUF_W-1:0]  bit_buffer;
  logic [FILL_W-1:0] bit_fill;
  logic [CW-1:0]     code_width;
  logic [NW-1:0]     next_code;
  logic [AW-1:0]     prev_code;
  logic              have_prev;
  logic [CNT_W-1:0]  bytes_out;
  ended_t            ended;
  logic              closed;
  logic [NW-1:0]     depth;
  logic [AW-1:0]     cur;
  logic [AW-1:0]     code_reg;
  logic              kwkwk;
  logic [7:0]        fprev;
  logic [CNT_W-1:0]  out_limit;

  logic [BUF_W-1:0]  shifted;
  logic [CB-1:0]     code_mask;
  logic [CB-1:0]     code;
  logic [31:0]       code32;
  logic [FILL_W-1:0] width_f;
  code_kind_t        kind;

  logic [AW-1:0]     prefix_rd;
  logic [7:0]        suffix_rd;
  logic [7:0]        first_rd;
  logic [7:0]        stack_rd;
  logic              stack_we;
  logic [7:0]        stack_wd;
  logic              dict_we;
  logic [7:0]        fp;
  logic [5:0]        blen;
  logic [CW-1:0]     width_upd;

  assign width_f   = FILL_W'(code_width);
  assign shifted   = bit_buffer >> (bit_fill - width_f);
  assign code_mask = CB'((32'd1 << code_width) - 32'd1);
  assign code      = CB'(shifted) & code_mask;
  assign code32    = 32'(code);

  always_comb begin
    if (code32 == CODE_CLEAR) begin
      kind = CK_CLEAR;
    end else if (code32 == CODE_END) begin
      kind = CK_END;
    end else if (!have_prev) begin
      kind = (code32 >= 32'd256) ? CK_BAD : CK_LIT;
    end else if (code32 > 32'(next_code) || code32 >= DICT_SIZE) begin
      kind = CK_BAD;
    end else begin
      kind = CK_DATA;
    end
  end

  assign stat.ended       = ended;
  assign stat.closed      = closed;
  assign stat.fill_full   = bit_fill > FILL_W'(FILL_FULL_AT);
  assign stat.limit_hit   = bytes_out >= out_limit;
  assign stat.stack_empty = depth == '0;
  assign stat.bits_short  = bit_fill < width_f;
  assign stat.code_kind   = kind;
  assign stat.cur_lit     = 32'(cur) < CODE_FIRST;

  assign fp      = (32'(prev_code) < 32'd256) ? prev_code[7:0] : first_rd;
  assign dict_we = (cmd.op == DP_TERM) && (32'(next_code) < DICT_SIZE);
  assign blen    = bit_len(32'(next_code) + 32'd2);
  assign width_upd = (32'(blen) > MAX_CODE_BITS) ? CW'(MAX_CODE_BITS) : CW'(blen);

  always_comb begin
    stack_we = 1'b0;
    stack_wd = 8'd0;
    case (cmd.op)
      DP_FIRSTLIT: begin
        stack_we = 1'b1;
        stack_wd = code32[7:0];
      end
      DP_FIRST: begin
        stack_we = kwkwk;
        stack_wd = fp;
      end
      DP_WALK: begin
        stack_we = 1'b1;
        stack_wd = suffix_rd;
      end
      DP_TERM: begin
        stack_we = 1'b1;
        stack_wd = cur[7:0];
      end
      default: stack_we = 1'b0;
    endcase
  end

  lzwsd_ram #(.WIDTH(AW), .DEPTH(DICT_SIZE)) u_prefix (
    .clk(clk), .we(dict_we), .waddr(next_code[AW-1:0]), .wdata(prev_code),
    .raddr(cur), .rdata(prefix_rd)
  );

  lzwsd_ram #(.WIDTH(8), .DEPTH(DICT_SIZE)) u_suffix (
    .clk(clk), .we(dict_we), .waddr(next_code[AW-1:0]), .wdata(cur[7:0]),
    .raddr(cur), .rdata(suffix_rd)
  );

  lzwsd_ram #(.WIDTH(8), .DEPTH(DICT_SIZE)) u_first (
    .clk(clk), .we(dict_we), .waddr(next_code[AW-1:0]), .wdata(fprev),
    .raddr(prev_code), .rdata(first_rd)
  );

  lzwsd_ram #(.WIDTH(8), .DEPTH(DICT_SIZE)) u_stack (
    .clk(clk), .we(stack_we), .waddr(depth[AW-1:0]), .wdata(stack_wd),
    .raddr(AW'(depth - NW'(1))), .rdata(stack_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer <= '0;
      bit_fill   <= '0;
      code_width <= CW'(START_BITS);
      next_code  <= NW'(CODE_FIRST);
      prev_code  <= '0;
      have_prev  <= 1'b0;
      bytes_out  <= '0;
      ended      <= END_RUN;
      closed     <= 1'b0;
      depth      <= '0;
      out_limit  <= '1;
    end else begin
      if (cfg_we) begin
        out_limit <= cfg_wdata;
      end
      if (cmd.set_ended) begin
        ended <= cmd.ended_val;
      end
      if (stack_we) begin
        depth <= depth + NW'(1);
      end
      case (cmd.op)
        DP_PUSH: begin
          bit_buffer <= {bit_buffer[BUF_W-9:0], in_data.in_byte};
          bit_fill   <= bit_fill + FILL_W'(8);
          if (in_data.in_last) begin
            closed <= 1'b1;
          end
        end
        DP_CONSUME: begin
          bit_fill   <= bit_fill - width_f;
          code_width <= CW'(START_BITS);
          next_code  <= NW'(CODE_FIRST);
          have_prev  <= 1'b0;
        end
        DP_FIRSTLIT: begin
          bit_fill  <= bit_fill - width_f;
          prev_code <= code32[AW-1:0];
          have_prev <= 1'b1;
        end
        DP_START: begin
          bit_fill <= bit_fill - width_f;
        end
        DP_TERM: begin
          prev_code <= code_reg;
          if (dict_we) begin
            next_code  <= next_code + NW'(1);
            code_width <= width_upd;
          end
        end
        DP_POP: begin
          depth     <= depth - NW'(1);
          bytes_out <= bytes_out + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_START: begin
        cur      <= code32[AW-1:0];
        code_reg <= code32[AW-1:0];
        kwkwk    <= code32 == 32'(next_code);
      end
      DP_FIRST: begin
        fprev <= fp;
        if (kwkwk) begin
          cur <= prev_code;
        end
      end
      DP_WALK: cur <= prefix_rd;
      default: ;
    endcase
    if (cmd.out_load) begin
      out_data.status <= cmd.out_status;
      if (cmd.op == DP_POP) begin
        out_data.out_byte  <= stack_rd;
        out_data.out_count <= bytes_out + CNT_W'(1);
      end else begin
        out_data.out_byte  <= 8'd0;
        out_data.out_count <= bytes_out;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lzw_stream_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_stream_decoder_core
// msb-first lzw decoder with early change, 9 to MAX_CODE_BITS bit codes
// ----------------------------------------------------------------------------
// usage:
//   in channel: func 0 pushes one compressed byte into a 24-bit bit buffer,
//   func 1 pulls one decoded byte. every transaction gives exactly one
//   result transaction (status, byte, delivered count) on the out channel.
//   cfg_we writes out_limit, the most bytes delivered before finishing.
// sequencing:
//   a push or a terminal pull answers from the idle state; a pull with bytes
//   waiting on the expansion stack goes straight to pop (registered stack
//   read). a pull that needs a new code runs fetch, read, pop for a first
//   literal after a clear and fetch, first, walk, read, pop for any other
//   code, with a walkd and walk step per chain step through the prefix/suffix
//   tables; each clear code adds a fetch. registered ram reads set these steps.
// reset:
//   rst clears the bit buffer, counters, dictionary size and end flags;
//   table contents are undefined and are only read once written.
// stalls:
//   the result sits in an output register; while it is held by out_stall
//   the in channel stalls too.
// ----------------------------------------------------------------------------
module lzw_stream_decoder_core
  import lzwsd_pkg::*;
#(
  parameter int DICT_SIZE     = LZWSD_DICT_SIZE,
  parameter int MAX_CODE_BITS = LZWSD_MAX_CODE_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lzwsd_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_func(in_data.func), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  lzwsd_dpath #(.DICT_SIZE(DICT_SIZE), .MAX_CODE_BITS(MAX_CODE_BITS)) u_dpath (
    .clk(clk), .rst(rst),
    .in_data(in_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .stat(stat), .out_data(out_data)
  );

  a_no_accept_while_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while result held");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_BYTE) |-> (out_data.out_byte == 8'd0))
    else $error("nonzero byte on non-byte result");

  a_byte_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_BYTE) |-> (out_data.out_count != '0))
    else $error("byte result with zero count");

endmodule
`default_nettype wire
